@@ src/c_lex_pkg.sv @@
// Shared types, token codes and character helpers for the C subset lexer.
// No dependencies.
package c_lex_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int LINE_BITS_DEF   = 16;
    localparam int Q_DEPTH         = 4;
    localparam int Q_PTR_BITS      = 2;
    localparam int Q_CNT_BITS      = 3;

    localparam logic [5:0] TK_ID     = 6'd0;
    localparam logic [5:0] TK_INT    = 6'd1;
    localparam logic [5:0] TK_REAL   = 6'd2;
    localparam logic [5:0] TK_CHR    = 6'd3;
    localparam logic [5:0] TK_STR    = 6'd4;
    localparam logic [5:0] TK_COMMA  = 6'd5;
    localparam logic [5:0] TK_SEMI   = 6'd6;
    localparam logic [5:0] TK_LPAR   = 6'd7;
    localparam logic [5:0] TK_RPAR   = 6'd8;
    localparam logic [5:0] TK_LBRK   = 6'd9;
    localparam logic [5:0] TK_RBRK   = 6'd10;
    localparam logic [5:0] TK_LACC   = 6'd11;
    localparam logic [5:0] TK_RACC   = 6'd12;
    localparam logic [5:0] TK_ADD    = 6'd13;
    localparam logic [5:0] TK_SUB    = 6'd14;
    localparam logic [5:0] TK_MUL    = 6'd15;
    localparam logic [5:0] TK_DOT    = 6'd16;
    localparam logic [5:0] TK_AND    = 6'd17;
    localparam logic [5:0] TK_OR     = 6'd18;
    localparam logic [5:0] TK_ASSIGN = 6'd19;
    localparam logic [5:0] TK_EQUAL  = 6'd20;
    localparam logic [5:0] TK_NOT    = 6'd21;
    localparam logic [5:0] TK_NOTEQ  = 6'd22;
    localparam logic [5:0] TK_LESS   = 6'd23;
    localparam logic [5:0] TK_LESSEQ = 6'd24;
    localparam logic [5:0] TK_GT     = 6'd25;
    localparam logic [5:0] TK_GTEQ   = 6'd26;
    localparam logic [5:0] TK_DIV    = 6'd27;
    localparam logic [5:0] KW_BREAK  = 6'd28;
    localparam logic [5:0] KW_CHAR   = 6'd29;
    localparam logic [5:0] KW_DOUBLE = 6'd30;
    localparam logic [5:0] KW_ELSE   = 6'd31;
    localparam logic [5:0] KW_FOR    = 6'd32;
    localparam logic [5:0] KW_IF     = 6'd33;
    localparam logic [5:0] KW_INT    = 6'd34;
    localparam logic [5:0] KW_STRUCT = 6'd35;
    localparam logic [5:0] KW_VOID   = 6'd36;
    localparam logic [5:0] KW_WHILE  = 6'd37;
    localparam logic [5:0] KW_SWITCH = 6'd38;
    localparam logic [5:0] KW_RETURN = 6'd39;
    localparam logic [5:0] TK_END    = 6'd40;
    localparam logic [5:0] TK_ERR    = 6'd41;

    localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [5:0]  code;
        logic [15:0] line;
        logic [15:0] start;
        logic [15:0] len;
        logic [30:0] val;
        logic        ovf;
        logic        last;
    } t_tok;

    // front to queue: up to two tokens per byte
    typedef struct packed {
        logic [1:0] n;
        t_tok       tok0;
        t_tok       tok1;
    } t_push;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // {valid, digit}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (is_dig(c)) begin
            d = c - 8'd48;
            return {1'b1, d[3:0]};
        end
        if (c >= "a" && c <= "f") begin
            d = c - 8'd87;
            return {1'b1, d[3:0]};
        end
        if (c >= "A" && c <= "F") begin
            d = c - 8'd55;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // {valid, value}
    function automatic logic [8:0] esc_value(input logic [7:0] c);
        case (c)
            "a":  return {1'b1, 8'd7};
            "b":  return {1'b1, 8'd8};
            "f":  return {1'b1, 8'd12};
            "n":  return {1'b1, 8'd10};
            "r":  return {1'b1, 8'd13};
            "t":  return {1'b1, 8'd9};
            "v":  return {1'b1, 8'd11};
            "0":  return {1'b1, 8'd0};
            8'h27, 8'h22, 8'h3F, 8'h5C: return {1'b1, c};
            default: return 9'd0;
        endcase
    endfunction

    // keyword lookup by length and stored characters
    function automatic logic [5:0] kw_code(input logic [2:0] len,
                                           input logic [5:0][7:0] w);
        logic [5:0] r;
        r = TK_ID;
        unique case (len)
            3'd2: if ({w[0], w[1]} == "if") r = KW_IF;
            3'd3: begin
                if ({w[0], w[1], w[2]} == "for") r = KW_FOR;
                if ({w[0], w[1], w[2]} == "int") r = KW_INT;
            end
            3'd4: begin
                if ({w[0], w[1], w[2], w[3]} == "else") r = KW_ELSE;
                if ({w[0], w[1], w[2], w[3]} == "char") r = KW_CHAR;
                if ({w[0], w[1], w[2], w[3]} == "void") r = KW_VOID;
            end
            3'd5: begin
                if ({w[0], w[1], w[2], w[3], w[4]} == "while") r = KW_WHILE;
                if ({w[0], w[1], w[2], w[3], w[4]} == "break") r = KW_BREAK;
            end
            3'd6: begin
                if ({w[0], w[1], w[2], w[3], w[4], w[5]} == "switch") r = KW_SWITCH;
                if ({w[0], w[1], w[2], w[3], w[4], w[5]} == "double") r = KW_DOUBLE;
                if ({w[0], w[1], w[2], w[3], w[4], w[5]} == "return") r = KW_RETURN;
                if ({w[0], w[1], w[2], w[3], w[4], w[5]} == "struct") r = KW_STRUCT;
            end
            default: r = TK_ID;
        endcase
        return r;
    endfunction

endpackage

@@ src/c_lex_if.sv @@
// Handshake interfaces: source byte stream and token stream.
// No dependencies.
interface c_lex_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    modport source (output valid, output src_byte, input ready);
    modport sink   (input valid, input src_byte, output ready);
endinterface

interface c_lex_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_code;
    logic [15:0] token_line;
    logic [15:0] lexeme_start;
    logic [15:0] lexeme_len;
    logic [30:0] int_value;
    logic        value_overflow;
    logic        last_of_run;
    modport source (output valid, output token_code, output token_line,
                    output lexeme_start, output lexeme_len, output int_value,
                    output value_overflow, output last_of_run, input ready);
    modport sink   (input valid, input token_code, input token_line,
                    input lexeme_start, input lexeme_len, input int_value,
                    input value_overflow, input last_of_run, output ready);
endinterface

@@ src/c_lex_front.sv @@
// Scanner front: takes one byte per cycle while the queue has room, runs the DFA, builds 0..2 tokens.
// Depends on c_lex_pkg.
module c_lex_front #(
    parameter int OFFSET_BITS = c_lex_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = c_lex_pkg::LINE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_room,
    output logic              o_ready,
    output c_lex_pkg::t_push  o_push
);
    import c_lex_pkg::*;

    localparam logic [4:0] ST_START = 5'd0,  ST_IDENT = 5'd1,  ST_ZERO = 5'd2,
        ST_INT = 5'd3, ST_HEXPRE = 5'd4, ST_LEADZ = 5'd5, ST_FRACDOT = 5'd6,
        ST_FRAC = 5'd7, ST_EXP = 5'd8, ST_EXPSIGN = 5'd9, ST_EXPDIG = 5'd10,
        ST_CHOPEN = 5'd11, ST_CHESC = 5'd12, ST_CHCLOSE = 5'd13, ST_STR = 5'd14,
        ST_STRESC = 5'd15, ST_SLASH = 5'd16, ST_LINECMT = 5'd17, ST_BLOCK = 5'd18,
        ST_BLOCKSTAR = 5'd19, ST_BANG = 5'd20, ST_EQ = 5'd21, ST_LT = 5'd22,
        ST_GT = 5'd23, ST_AMP = 5'd24, ST_BAR = 5'd25;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    logic [4:0]             r_state, n_state;
    logic [LINE_BITS-1:0]   r_line;
    logic [OFFSET_BITS-1:0] r_pos, r_tstart, n_tstart;
    logic [31:0]            r_acc, n_acc;
    logic [1:0]             r_base, n_base;
    logic [5:0][7:0]        r_word, n_word;
    logic [2:0]             r_wlen, n_wlen;
    logic [7:0]             r_char, n_char;
    t_push                  n_push;
    logic                   accept;

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;

    always_comb begin
        logic [7:0]             b;
        logic                   e1, e2, resc, do_begin, alnum;
        t_tok                   t1, t2;
        logic [OFFSET_BITS-1:0] len_b, len_i;
        logic [31:0]            line32, ts32, cur32, lb32, li32;
        logic [4:0]             h;
        logic [8:0]             esc;
        logic [34:0]            nv;
        logic [30:0]            v;

        b = i_byte;
        n_state = r_state; n_tstart = r_tstart; n_acc = r_acc; n_base = r_base;
        n_word = r_word; n_wlen = r_wlen; n_char = r_char;
        e1 = 1'b0; e2 = 1'b0; resc = 1'b0;
        len_b = r_pos - r_tstart;
        len_i = r_pos + 1'b1 - r_tstart;
        line32 = 32'(r_line);
        ts32 = 32'(r_tstart); cur32 = 32'(r_pos);
        lb32 = 32'(len_b); li32 = 32'(len_i);
        h = hex_val(b);
        esc = esc_value(b);
        alnum = is_alpha(b) || is_dig(b) || b == "_";
        v = r_acc[30:0];
        unique case (r_base)
            2'd0:    nv = (35'(v) << 3) + (35'(v) << 1) + 35'(h[3:0]);
            2'd1:    nv = (35'(v) << 3) + 35'(h[3:0]);
            default: nv = (35'(v) << 4) + 35'(h[3:0]);
        endcase

        t1 = '0; t1.line = line32[15:0]; t1.start = ts32[15:0]; t1.len = lb32[15:0];
        t2 = '0; t2.line = line32[15:0]; t2.start = cur32[15:0]; t2.len = 16'd1;

        unique case (r_state)
            ST_START: ;
            ST_IDENT: begin
                if (alnum) begin
                    if (r_wlen < 3'd6) n_word[r_wlen] = b;
                    if (r_wlen < 3'd7) n_wlen = r_wlen + 3'd1;
                end else begin
                    e1 = 1'b1; resc = 1'b1; t1.code = kw_code(r_wlen, r_word);
                end
            end
            ST_ZERO: begin
                if (b == "x" || b == "X") begin
                    n_base = 2'd2; n_state = ST_HEXPRE;
                end else if (b >= "0" && b <= "7") begin
                    n_base = 2'd1; n_acc = 32'(h[3:0]); n_state = ST_INT;
                end else if (b == "8" || b == "9") n_state = ST_LEADZ;
                else if (b == ".") n_state = ST_FRACDOT;
                else if (b == "e" || b == "E") n_state = ST_EXP;
                else begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_INT;
                end
            end
            ST_INT: begin
                if (r_base == 2'd2 && h[4]) begin
                    n_acc = (nv > 35'(VAL_MAX)) ? {1'b1, VAL_MAX} : {r_acc[31], nv[30:0]};
                end else if (r_base != 2'd2 && r_base == 2'd1 && (b == "8" || b == "9"))
                    n_state = ST_LEADZ;
                else if (r_base != 2'd2 && is_dig(b)) begin
                    n_acc = (nv > 35'(VAL_MAX)) ? {1'b1, VAL_MAX} : {r_acc[31], nv[30:0]};
                end else if (r_base != 2'd2 && b == ".") n_state = ST_FRACDOT;
                else if (r_base != 2'd2 && (b == "e" || b == "E")) n_state = ST_EXP;
                else begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_INT;
                    t1.val = r_acc[30:0]; t1.ovf = r_acc[31];
                end
            end
            ST_HEXPRE: begin
                if (h[4]) begin
                    n_acc = 32'(h[3:0]); n_state = ST_INT;
                end else begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_ERR;
                end
            end
            ST_LEADZ: begin
                if (is_dig(b)) ;
                else if (b == ".") n_state = ST_FRACDOT;
                else if (b == "e" || b == "E") n_state = ST_EXP;
                else begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_ERR;
                end
            end
            ST_FRACDOT: begin
                if (is_dig(b)) n_state = ST_FRAC;
                else begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_ERR;
                end
            end
            ST_FRAC: begin
                if (is_dig(b)) ;
                else if (b == "e" || b == "E") n_state = ST_EXP;
                else begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_REAL;
                end
            end
            ST_EXP: begin
                if (b == "+" || b == "-") n_state = ST_EXPSIGN;
                else if (is_dig(b)) n_state = ST_EXPDIG;
                else begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_ERR;
                end
            end
            ST_EXPSIGN: begin
                if (is_dig(b)) n_state = ST_EXPDIG;
                else begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_ERR;
                end
            end
            ST_EXPDIG: begin
                if (!is_dig(b)) begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_REAL;
                end
            end
            ST_CHOPEN: begin
                if (b == 8'd0) begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_ERR;
                end else if (b == 8'h5C) n_state = ST_CHESC;
                else if (b == 8'h27) begin
                    // empty character constant
                    e1 = 1'b1; t1.code = TK_ERR; t1.len = li32[15:0]; n_state = ST_START;
                end else begin
                    n_char = b; n_state = ST_CHCLOSE;
                end
            end
            ST_CHESC: begin
                if (esc[8]) begin
                    n_char = esc[7:0]; n_state = ST_CHCLOSE;
                end else begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_ERR;
                end
            end
            ST_CHCLOSE: begin
                if (b == 8'h27) begin
                    e1 = 1'b1; t1.code = TK_CHR; t1.len = li32[15:0];
                    t1.val = 31'(r_char); n_state = ST_START;
                end else begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_ERR;
                end
            end
            ST_STR: begin
                if (b == 8'd0) begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_ERR;
                end else if (b == 8'h5C) n_state = ST_STRESC;
                else if (b == 8'h22) begin
                    e1 = 1'b1; t1.code = TK_STR; t1.len = li32[15:0]; n_state = ST_START;
                end
            end
            ST_STRESC: begin
                if (esc[8]) n_state = ST_STR;
                else begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_ERR;
                end
            end
            ST_SLASH: begin
                if (b == "/") n_state = ST_LINECMT;
                else if (b == "*") n_state = ST_BLOCK;
                else begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_DIV;
                end
            end
            ST_LINECMT: begin
                if (b == 8'h0A || b == 8'h0D) n_state = ST_START;
                else if (b == 8'd0) resc = 1'b1;
            end
            ST_BLOCK: begin
                if (b == 8'd0) begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_ERR;
                end else if (b == "*") n_state = ST_BLOCKSTAR;
            end
            ST_BLOCKSTAR: begin
                if (b == 8'd0) begin
                    e1 = 1'b1; resc = 1'b1; t1.code = TK_ERR;
                end else if (b == "/") n_state = ST_START;
                else if (b != "*") n_state = ST_BLOCK;
            end
            ST_BANG, ST_EQ, ST_LT, ST_GT: begin
                e1 = 1'b1;
                if (b == "=") begin
                    t1.len = li32[15:0]; n_state = ST_START;
                    unique case (r_state)
                        ST_BANG: t1.code = TK_NOTEQ;
                        ST_EQ:   t1.code = TK_EQUAL;
                        ST_LT:   t1.code = TK_LESSEQ;
                        default: t1.code = TK_GTEQ;
                    endcase
                end else begin
                    resc = 1'b1;
                    unique case (r_state)
                        ST_BANG: t1.code = TK_NOT;
                        ST_EQ:   t1.code = TK_ASSIGN;
                        ST_LT:   t1.code = TK_LESS;
                        default: t1.code = TK_GT;
                    endcase
                end
            end
            ST_AMP, ST_BAR: begin
                e1 = 1'b1;
                if ((r_state == ST_AMP && b == "&") || (r_state == ST_BAR && b == "|")) begin
                    t1.len = li32[15:0]; n_state = ST_START;
                    t1.code = (r_state == ST_AMP) ? TK_AND : TK_OR;
                end else begin
                    resc = 1'b1; t1.code = TK_ERR;
                end
            end
            default: resc = 1'b1;
        endcase

        if (resc) n_state = ST_START;
        do_begin = (r_state == ST_START) || resc;

        // start-state scan of the byte
        if (do_begin) begin
            n_tstart = r_pos;
            n_state  = ST_START;
            if (is_alpha(b) || b == "_") begin
                n_word[0] = b; n_wlen = 3'd1; n_state = ST_IDENT;
            end else if (b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D) ;
            else if (b >= "1" && b <= "9") begin
                n_acc = 32'(h[3:0]); n_base = 2'd0; n_state = ST_INT;
            end else begin
                unique case (b)
                    "0": begin
                        n_acc = 32'd0; n_base = 2'd0; n_state = ST_ZERO;
                    end
                    8'h27: begin
                        n_char = 8'd0; n_state = ST_CHOPEN;
                    end
                    8'h22: n_state = ST_STR;
                    "/": n_state = ST_SLASH;
                    "!": n_state = ST_BANG;
                    "=": n_state = ST_EQ;
                    "<": n_state = ST_LT;
                    ">": n_state = ST_GT;
                    "&": n_state = ST_AMP;
                    "|": n_state = ST_BAR;
                    ",": begin e2 = 1'b1; t2.code = TK_COMMA; end
                    ";": begin e2 = 1'b1; t2.code = TK_SEMI;  end
                    "(": begin e2 = 1'b1; t2.code = TK_LPAR;  end
                    ")": begin e2 = 1'b1; t2.code = TK_RPAR;  end
                    "[": begin e2 = 1'b1; t2.code = TK_LBRK;  end
                    "]": begin e2 = 1'b1; t2.code = TK_RBRK;  end
                    "{": begin e2 = 1'b1; t2.code = TK_LACC;  end
                    "}": begin e2 = 1'b1; t2.code = TK_RACC;  end
                    "+": begin e2 = 1'b1; t2.code = TK_ADD;   end
                    "-": begin e2 = 1'b1; t2.code = TK_SUB;   end
                    "*": begin e2 = 1'b1; t2.code = TK_MUL;   end
                    ".": begin e2 = 1'b1; t2.code = TK_DOT;   end
                    8'd0: begin e2 = 1'b1; t2.code = TK_END; t2.len = 16'd0; end
                    default: begin e2 = 1'b1; t2.code = TK_ERR; end
                endcase
            end
        end

        n_push = '0;
        if (e1 && e2) begin
            n_push.n = 2'd2; n_push.tok0 = t1; n_push.tok1 = t2; n_push.tok1.last = 1'b1;
        end else if (e1) begin
            n_push.n = 2'd1; n_push.tok0 = t1; n_push.tok0.last = 1'b1;
        end else if (e2) begin
            n_push.n = 2'd1; n_push.tok0 = t2; n_push.tok0.last = 1'b1;
        end
        if (!accept) n_push.n = 2'd0;
    end

    assign o_push = n_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_START;
            r_line   <= LINE_BITS'(1);
            r_pos    <= '0;
            r_tstart <= '0;
            r_acc    <= '0;
            r_base   <= 2'd0;
            r_wlen   <= 3'd0;
            r_char   <= 8'd0;
        end else if (accept) begin
            r_state  <= n_state;
            r_pos    <= r_pos + 1'b1;
            r_tstart <= n_tstart;
            r_acc    <= n_acc;
            r_base   <= n_base;
            r_wlen   <= n_wlen;
            r_char   <= n_char;
            if (i_byte == 8'h0A && r_line != LINE_MAX) r_line <= r_line + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_word <= n_word;
    end

endmodule

@@ src/c_lex_back.sv @@
// Token queue and output side: takes 0..2 tokens a cycle, hands out one when the sink is ready.
// Depends on c_lex_pkg.
module c_lex_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  c_lex_pkg::t_push i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output c_lex_pkg::t_tok  o_tok
);
    import c_lex_pkg::*;

    t_tok                  r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr, r_rd;
    logic [Q_CNT_BITS-1:0] r_cnt;
    logic                  pop;

    assign o_valid = r_cnt != '0;
    assign o_tok   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign o_room  = r_cnt <= Q_CNT_BITS'(Q_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + Q_PTR_BITS'(i_push.n);
            r_rd  <= r_rd + Q_PTR_BITS'(pop);
            r_cnt <= r_cnt + Q_CNT_BITS'(i_push.n) - Q_CNT_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) r_mem[r_wr] <= i_push.tok0;
        if (i_push.n == 2'd2) r_mem[r_wr + 1'b1] <= i_push.tok1;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_BITS'(Q_DEPTH)) else $error("token queue overrun");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.n == 2'd0 && !pop |=> r_cnt == $past(r_cnt))
        else $error("queue count moved without traffic");

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.n == 2'd2 |-> !i_push.tok0.last && i_push.tok1.last)
        else $error("last mark misplaced on token pair");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.n != 2'd0 |-> $past(o_room) || r_cnt <= Q_CNT_BITS'(Q_DEPTH - 2))
        else $error("push without room");

endmodule

@@ src/c_subset_lexer_core.sv @@
// Top level of the C subset lexer: scanner front plus token queue back end.
// Depends on c_lex_pkg, c_lex_if, c_lex_front, c_lex_back.
//
//  channel   | dir | item                | payload
//  ----------+-----+---------------------+------------------------------------
//  i_src     | in  | one source byte     | src_byte (0 = end of input)
//  o_tok     | out | one token           | code, line, start, len, value, ovf,
//            |     |                     | last_of_run
//
// Cycles: one byte per cycle when the output keeps up; the DFA resolves the
// byte and a rescan from the start state in the same cycle.
// A byte yields 0..2 tokens; the four-entry token queue drains one per cycle
// when the sink is ready, so two-token byte bursts run at the output rate.
// Input ready drops when fewer than two queue entries are free.
// Reset (synchronous, active low) puts the scanner in the start state, line 1,
// offset 0, and empties the queue. No clearing pass.
module c_subset_lexer_core #(
    parameter int OFFSET_BITS = c_lex_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = c_lex_pkg::LINE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    c_lex_byte_if.sink   i_src,
    c_lex_tok_if.source  o_tok
);
    import c_lex_pkg::*;

    t_push push;
    t_tok  head;
    logic  room;

    // front: DFA, position and line counters, identifier buffer
    c_lex_front #(
        .OFFSET_BITS(OFFSET_BITS),
        .LINE_BITS  (LINE_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_src.valid),
        .i_byte (i_src.src_byte),
        .i_room (room),
        .o_ready(i_src.ready),
        .o_push (push)
    );

    // back: token queue, output handshake
    c_lex_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_room (room),
        .o_valid(o_tok.valid),
        .i_ready(o_tok.ready),
        .o_tok  (head)
    );

    assign o_tok.token_code     = head.code;
    assign o_tok.token_line     = head.line;
    assign o_tok.lexeme_start   = head.start;
    assign o_tok.lexeme_len     = head.len;
    assign o_tok.int_value      = head.val;
    assign o_tok.value_overflow = head.ovf;
    assign o_tok.last_of_run    = head.last;

endmodule

@@ test/c_subset_lexer_core_test.sv @@
// Self-checking testbench for c_subset_lexer_core: a byte-level scanner model
// predicts every token, and a checker compares the token stream field by field.
// Depends on c_lex_pkg, c_lex_if and the lexer RTL.
`timescale 1ns / 100ps

module c_subset_lexer_core_test;
    import c_lex_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    c_lex_byte_if src ();
    c_lex_tok_if  tok ();

    c_subset_lexer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src.sink),
        .o_tok   (tok.source)
    );

    // scanner states of the token model
    typedef enum logic [4:0] {
        SC_START, SC_IDENT, SC_ZERO, SC_INT, SC_HEXPRE, SC_LEADZ, SC_FRACDOT,
        SC_FRAC, SC_EXP, SC_EXPSIGN, SC_EXPDIG, SC_CHOPEN, SC_CHESC, SC_CHCLOSE,
        SC_STR, SC_STRESC, SC_SLASH, SC_LINECMT, SC_BLOCK, SC_BLOCKSTAR,
        SC_BANG, SC_EQ, SC_LT, SC_GT, SC_AMP, SC_BAR
    } t_scan;

    localparam int BASE_DEC = 0;
    localparam int BASE_OCT = 1;
    localparam int BASE_HEX = 2;

    // token model state
    t_scan       lx_state;
    logic [15:0] lx_line;
    logic [15:0] lx_pos;
    logic [15:0] lx_start;
    logic [31:0] lx_acc;      // bit 31 = saturated
    logic [1:0]  lx_base;
    logic [7:0]  lx_word [6];
    logic [2:0]  lx_wlen;
    logic [7:0]  lx_chr;
    logic [15:0] lx_cur;

    t_tok        new_toks [2];
    int          new_cnt;
    t_tok        token_q [$];

    bit          src_idle_on = 1'b1;
    bit          tok_idle_on = 1'b1;
    int          mismatches  = 0;
    int          tokens_seen = 0;
    int          bytes_sent  = 0;

    function automatic bit alpha_c(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit digit_c(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (digit_c(c)) return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic bit exp_c(input logic [7:0] c);
        return c == "e" || c == "E";
    endfunction

    // escape decode: returns 1 if known, value through v
    function automatic bit escape_code(input logic [7:0] c, output logic [7:0] v);
        v = c;
        case (c)
            "a": v = 8'd7;
            "b": v = 8'd8;
            "f": v = 8'd12;
            "n": v = 8'd10;
            "r": v = 8'd13;
            "t": v = 8'd9;
            "v": v = 8'd11;
            "0": v = 8'd0;
            8'h27, 8'h22, 8'h3F, 8'h5C: v = c;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic logic [5:0] word_token();
        string s;
        s = "";
        if (lx_wlen > 3'd6) return TK_ID;
        for (int i = 0; i < lx_wlen; i++) s = {s, " "};
        for (int i = 0; i < lx_wlen; i++) s[i] = lx_word[i];
        case (s)
            "if":     return KW_IF;
            "for":    return KW_FOR;
            "int":    return KW_INT;
            "else":   return KW_ELSE;
            "char":   return KW_CHAR;
            "void":   return KW_VOID;
            "while":  return KW_WHILE;
            "break":  return KW_BREAK;
            "switch": return KW_SWITCH;
            "double": return KW_DOUBLE;
            "return": return KW_RETURN;
            "struct": return KW_STRUCT;
            default:  return TK_ID;
        endcase
    endfunction

    function automatic void add_token(input logic [5:0] code, input logic [15:0] st,
                                      input logic [15:0] len, input logic [30:0] val,
                                      input logic ovf);
        t_tok t;
        t.code  = code;
        t.line  = lx_line;
        t.start = st;
        t.len   = len;
        t.val   = val;
        t.ovf   = ovf;
        t.last  = 1'b0;
        if (new_cnt < 2) new_toks[new_cnt] = t;
        new_cnt++;
    endfunction

    // close before the current byte; byte is rescanned
    function automatic bit close_before(input logic [5:0] code, input logic [30:0] val,
                                        input logic ovf);
        add_token(code, lx_start, lx_cur - lx_start, val, ovf);
        lx_state = SC_START;
        return 1'b1;
    endfunction

    // close including the current byte
    function automatic bit close_with(input logic [5:0] code, input logic [30:0] val);
        add_token(code, lx_start, lx_cur + 16'd1 - lx_start, val, 1'b0);
        lx_state = SC_START;
        return 1'b0;
    endfunction

    function automatic void add_digit(input int d);
        longint unsigned radix, nv;
        logic sat;
        radix = (lx_base == BASE_DEC) ? 10 : ((lx_base == BASE_OCT) ? 8 : 16);
        sat = lx_acc[31];
        nv = longint'(lx_acc[30:0]) * radix + d;
        if (nv > 64'h7FFF_FFFF) begin
            nv = 64'h7FFF_FFFF;
            sat = 1'b1;
        end
        lx_acc = {sat, nv[30:0]};
    endfunction

    function automatic void start_lexeme(input logic [7:0] b);
        logic [5:0] single;
        lx_start = lx_cur;
        if (alpha_c(b) || b == "_") begin
            lx_word[0] = b;
            lx_wlen = 3'd1;
            lx_state = SC_IDENT;
            return;
        end
        if (b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D) return;
        if (b >= "1" && b <= "9") begin
            lx_acc = 32'(b - "0");
            lx_base = BASE_DEC;
            lx_state = SC_INT;
            return;
        end
        case (b)
            "0": begin
                lx_acc = 0;
                lx_base = BASE_DEC;
                lx_state = SC_ZERO;
                return;
            end
            8'h27: begin
                lx_chr = 0;
                lx_state = SC_CHOPEN;
                return;
            end
            8'h22: begin lx_state = SC_STR; return; end
            "/": begin lx_state = SC_SLASH; return; end
            "!": begin lx_state = SC_BANG; return; end
            "=": begin lx_state = SC_EQ; return; end
            "<": begin lx_state = SC_LT; return; end
            ">": begin lx_state = SC_GT; return; end
            "&": begin lx_state = SC_AMP; return; end
            "|": begin lx_state = SC_BAR; return; end
            ",": single = TK_COMMA;
            ";": single = TK_SEMI;
            "(": single = TK_LPAR;
            ")": single = TK_RPAR;
            "[": single = TK_LBRK;
            "]": single = TK_RBRK;
            "{": single = TK_LACC;
            "}": single = TK_RACC;
            "+": single = TK_ADD;
            "-": single = TK_SUB;
            "*": single = TK_MUL;
            ".": single = TK_DOT;
            8'h00: begin
                add_token(TK_END, lx_cur, 16'd0, 31'd0, 1'b0);
                return;
            end
            default: single = TK_ERR;
        endcase
        add_token(single, lx_cur, 16'd1, 31'd0, 1'b0);
    endfunction

    // one pass of the scanner; returns 1 when the byte must be rescanned
    function automatic bit scan_pass(input logic [7:0] b);
        int h;
        logic [7:0] v;
        h = hex_digit(b);
        case (lx_state)
            SC_START: begin
                start_lexeme(b);
                return 1'b0;
            end
            SC_IDENT: begin
                if (alpha_c(b) || digit_c(b) || b == "_") begin
                    if (lx_wlen < 3'd6) lx_word[lx_wlen] = b;
                    if (lx_wlen < 3'd7) lx_wlen++;
                    return 1'b0;
                end
                return close_before(word_token(), 31'd0, 1'b0);
            end
            SC_ZERO: begin
                if (b == "x" || b == "X") begin
                    lx_base = BASE_HEX;
                    lx_state = SC_HEXPRE;
                    return 1'b0;
                end
                if (b >= "0" && b <= "7") begin
                    lx_base = BASE_OCT;
                    lx_acc = 32'(b - "0");
                    lx_state = SC_INT;
                    return 1'b0;
                end
                if (b == "8" || b == "9") begin lx_state = SC_LEADZ; return 1'b0; end
                if (b == ".") begin lx_state = SC_FRACDOT; return 1'b0; end
                if (exp_c(b)) begin lx_state = SC_EXP; return 1'b0; end
                return close_before(TK_INT, 31'd0, 1'b0);
            end
            SC_INT: begin
                if (lx_base >= BASE_HEX) begin
                    if (h >= 0) begin add_digit(h); return 1'b0; end
                end else begin
                    if (lx_base == BASE_OCT && (b == "8" || b == "9")) begin
                        lx_state = SC_LEADZ;
                        return 1'b0;
                    end
                    if (digit_c(b)) begin add_digit(h); return 1'b0; end
                    if (b == ".") begin lx_state = SC_FRACDOT; return 1'b0; end
                    if (exp_c(b)) begin lx_state = SC_EXP; return 1'b0; end
                end
                return close_before(TK_INT, lx_acc[30:0], lx_acc[31]);
            end
            SC_HEXPRE: begin
                if (h >= 0) begin
                    lx_acc = 32'(h);
                    lx_state = SC_INT;
                    return 1'b0;
                end
                return close_before(TK_ERR, 31'd0, 1'b0);
            end
            SC_LEADZ: begin
                if (digit_c(b)) return 1'b0;
                if (b == ".") begin lx_state = SC_FRACDOT; return 1'b0; end
                if (exp_c(b)) begin lx_state = SC_EXP; return 1'b0; end
                return close_before(TK_ERR, 31'd0, 1'b0);
            end
            SC_FRACDOT: begin
                if (digit_c(b)) begin lx_state = SC_FRAC; return 1'b0; end
                return close_before(TK_ERR, 31'd0, 1'b0);
            end
            SC_FRAC: begin
                if (digit_c(b)) return 1'b0;
                if (exp_c(b)) begin lx_state = SC_EXP; return 1'b0; end
                return close_before(TK_REAL, 31'd0, 1'b0);
            end
            SC_EXP: begin
                if (b == "+" || b == "-") begin lx_state = SC_EXPSIGN; return 1'b0; end
                if (digit_c(b)) begin lx_state = SC_EXPDIG; return 1'b0; end
                return close_before(TK_ERR, 31'd0, 1'b0);
            end
            SC_EXPSIGN: begin
                if (digit_c(b)) begin lx_state = SC_EXPDIG; return 1'b0; end
                return close_before(TK_ERR, 31'd0, 1'b0);
            end
            SC_EXPDIG: begin
                if (digit_c(b)) return 1'b0;
                return close_before(TK_REAL, 31'd0, 1'b0);
            end
            SC_CHOPEN: begin
                if (b == 8'h00) return close_before(TK_ERR, 31'd0, 1'b0);
                if (b == 8'h5C) begin lx_state = SC_CHESC; return 1'b0; end
                // empty char constant covers both quotes
                if (b == 8'h27) return close_with(TK_ERR, 31'd0);
                lx_chr = b;
                lx_state = SC_CHCLOSE;
                return 1'b0;
            end
            SC_CHESC: begin
                if (escape_code(b, v)) begin
                    lx_chr = v;
                    lx_state = SC_CHCLOSE;
                    return 1'b0;
                end
                return close_before(TK_ERR, 31'd0, 1'b0);
            end
            SC_CHCLOSE: begin
                if (b == 8'h27) return close_with(TK_CHR, 31'(lx_chr));
                return close_before(TK_ERR, 31'd0, 1'b0);
            end
            SC_STR: begin
                if (b == 8'h00) return close_before(TK_ERR, 31'd0, 1'b0);
                if (b == 8'h5C) begin lx_state = SC_STRESC; return 1'b0; end
                if (b == 8'h22) return close_with(TK_STR, 31'd0);
                return 1'b0;
            end
            SC_STRESC: begin
                if (escape_code(b, v)) begin lx_state = SC_STR; return 1'b0; end
                return close_before(TK_ERR, 31'd0, 1'b0);
            end
            SC_SLASH: begin
                if (b == "/") begin lx_state = SC_LINECMT; return 1'b0; end
                if (b == "*") begin lx_state = SC_BLOCK; return 1'b0; end
                return close_before(TK_DIV, 31'd0, 1'b0);
            end
            SC_LINECMT: begin
                if (b == 8'h0A || b == 8'h0D) begin lx_state = SC_START; return 1'b0; end
                // end of input inside a line comment still gives END
                if (b == 8'h00) begin lx_state = SC_START; return 1'b1; end
                return 1'b0;
            end
            SC_BLOCK: begin
                if (b == 8'h00) return close_before(TK_ERR, 31'd0, 1'b0);
                if (b == "*") lx_state = SC_BLOCKSTAR;
                return 1'b0;
            end
            SC_BLOCKSTAR: begin
                if (b == 8'h00) return close_before(TK_ERR, 31'd0, 1'b0);
                if (b == "/") lx_state = SC_START;
                else if (b != "*") lx_state = SC_BLOCK;
                return 1'b0;
            end
            SC_BANG: begin
                if (b == "=") return close_with(TK_NOTEQ, 31'd0);
                return close_before(TK_NOT, 31'd0, 1'b0);
            end
            SC_EQ: begin
                if (b == "=") return close_with(TK_EQUAL, 31'd0);
                return close_before(TK_ASSIGN, 31'd0, 1'b0);
            end
            SC_LT: begin
                if (b == "=") return close_with(TK_LESSEQ, 31'd0);
                return close_before(TK_LESS, 31'd0, 1'b0);
            end
            SC_GT: begin
                if (b == "=") return close_with(TK_GTEQ, 31'd0);
                return close_before(TK_GT, 31'd0, 1'b0);
            end
            SC_AMP: begin
                if (b == "&") return close_with(TK_AND, 31'd0);
                return close_before(TK_ERR, 31'd0, 1'b0);
            end
            SC_BAR: begin
                if (b == "|") return close_with(TK_OR, 31'd0);
                return close_before(TK_ERR, 31'd0, 1'b0);
            end
            default: begin
                lx_state = SC_START;
                return 1'b1;
            end
        endcase
    endfunction

    // expected tokens for one accepted byte
    function automatic void lex_byte(input logic [7:0] b);
        new_cnt = 0;
        lx_cur = lx_pos;
        if (scan_pass(b)) void'(scan_pass(b));
        if (new_cnt > 0) new_toks[new_cnt - 1].last = 1'b1;
        for (int i = 0; i < new_cnt; i++) token_q.push_back(new_toks[i]);
        if (b == 8'h0A && lx_line != 16'hFFFF) lx_line++;
        lx_pos = lx_cur + 16'd1;
    endfunction

    // byte monitor feeds the model
    always @(posedge i_clk) begin
        if (i_rst_n && src.valid && src.ready) lex_byte(src.src_byte);
    end

    // token checker
    always @(posedge i_clk) begin
        t_tok want;
        if (i_rst_n && tok.valid && tok.ready) begin
            tokens_seen++;
            if (token_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token code %0d start %0d", tok.token_code,
                             tok.lexeme_start);
            end else begin
                want = token_q.pop_front();
                if (tok.token_code !== want.code || tok.token_line !== want.line ||
                    tok.lexeme_start !== want.start || tok.lexeme_len !== want.len ||
                    tok.int_value !== want.val || tok.value_overflow !== want.ovf ||
                    tok.last_of_run !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("token mismatch: exp code %0d line %0d start %0d len %0d val %0d ovf %0d last %0d / got %0d %0d %0d %0d %0d %0d %0d",
                                 want.code, want.line, want.start, want.len, want.val,
                                 want.ovf, want.last, tok.token_code, tok.token_line,
                                 tok.lexeme_start, tok.lexeme_len, tok.int_value,
                                 tok.value_overflow, tok.last_of_run);
                end
            end
        end
    end

    // token sink stalls at random
    always @(negedge i_clk) begin
        tok.ready <= !(tok_idle_on && $urandom_range(0, 99) < 31);
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (src_idle_on && $urandom_range(0, 99) < 31) begin
            src.valid = 1'b0;
            @(negedge i_clk);
        end
        src.valid = 1'b1;
        src.src_byte = b;
        do @(posedge i_clk); while (!src.ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // drop valid, then wait until every expected token has been seen
    task automatic wait_drained();
        @(negedge i_clk);
        src.valid = 1'b0;
        while (token_q.size() != 0) @(posedge i_clk);
    endtask

    // every operator, keyword and special case once
    task automatic test_directed();
        send_text("if for while switch break double else char int return struct void");
        send_text(" ab_cdefgh _x9 0 07 0x1fA 0X 09 09.5 1.5e+3 2E7 1e 1e- . 0. 99999999999 ");
        send_text("'a' '\\n' '\\a''\\b''\\f''\\r''\\t''\\v''\\0''\\'''\\\"''\\?''\\\\' ");
        send_text("'' '\\q' 'ab \"s\\t\" \"\\z\" ,;()[]{}+-*/ && || & | ! != = == < <= > >= ");
        send_text("/* c* **/ // line\r");
        send_byte(8'h0B);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text("// tail");
        send_byte(8'h00);
        send_text("\"open");
        send_byte(8'h00);
        send_text("'");
        send_byte(8'h00);
        send_text("/* open *");
        send_byte(8'h00);
        send_text("x\n");
    endtask

    // sender holds off until the queue is empty
    task automatic test_drain_pause();
        wait_drained();
        repeat (8) @(posedge i_clk);
        send_text("a=b;\n");
        wait_drained();
    endtask

    // one random character of pool[0..hi]
    function automatic string pick(input string pool, input int hi);
        int k;
        k = $urandom_range(0, hi);
        return pool.substr(k, k);
    endfunction

    function automatic string rand_lexeme();
        string kw [12] = '{"if", "for", "while", "switch", "break", "double", "else",
                           "char", "int", "return", "struct", "void"};
        string ops [22] = '{",", ";", "(", ")", "[", "]", "{", "}", "+", "-", "*", ".",
                            "&&", "||", "=", "==", "!", "!=", "<", "<=", ">", ">="};
        string esc = "abfnrtv0'\"?\\";
        string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        string s;
        s = "";
        case ($urandom_range(0, 11))
            0: s = kw[$urandom_range(0, 11)];
            1, 2: begin
                s = pick(alnum, 52);
                repeat ($urandom_range(0, 8)) s = {s, pick(alnum, 62)};
            end
            3: s = $sformatf("%0d", $urandom_range(0, 3) == 0 ? {$urandom, $urandom} :
                             $urandom_range(0, 99999));
            4: s = ($urandom_range(0, 1) ? $sformatf("0x%0h", $urandom) :
                    $sformatf("0%0o", $urandom_range(0, 4095)));
            5: s = $sformatf("%0d.%0de%s%0d", $urandom_range(0, 99), $urandom_range(0, 9),
                             $urandom_range(0, 1) ? "-" : "", $urandom_range(0, 30));
            6: begin
                if ($urandom_range(0, 1)) s = {"'\\", pick(esc, 11), "'"};
                else s = {"'", pick(alnum, 62), "'"};
            end
            7: s = {"\"", pick(alnum, 30), "\\n", pick(alnum, 30), "\""};
            8: s = ($urandom_range(0, 1) ? "/* x * y */" : "// note\n");
            9, 10: s = ops[$urandom_range(0, 21)];
            default: begin
                // noise: any byte, broken lexemes included
                s = " ";
                s[0] = 8'($urandom_range(1, 255));
                if ($urandom_range(0, 3) == 0) s = "0x";
            end
        endcase
        return s;
    endfunction

    task automatic test_random_source();
        int start_cnt;
        start_cnt = bytes_sent;
        while (bytes_sent - start_cnt < 450) begin
            send_text(rand_lexeme());
            case ($urandom_range(0, 9))
                0: send_byte(8'h0A);
                1: send_byte(8'h00);
                2, 3, 4: ;
                default: send_byte(" ");
            endcase
        end
        send_byte(8'h00);
    endtask

    // no idling on either side: a stretch of back-to-back bytes and tokens
    task automatic test_no_idle();
        int start_cnt;
        src_idle_on = 1'b0;
        tok_idle_on = 1'b0;
        start_cnt = bytes_sent;
        while (bytes_sent - start_cnt < 120) begin
            send_text(rand_lexeme());
            send_byte(" ");
        end
        send_text("x\n");
        src_idle_on = 1'b1;
        tok_idle_on = 1'b1;
    endtask

    initial begin
        src.valid = 1'b0;
        src.src_byte = 8'h00;
        tok.ready = 1'b0;
        lx_state = SC_START;
        lx_line = 16'd1;
        lx_pos = 16'd0;
        lx_start = 16'd0;
        lx_acc = 32'd0;
        lx_base = BASE_DEC;
        lx_wlen = 3'd0;
        lx_chr = 8'd0;
        for (int i = 0; i < 6; i++) lx_word[i] = 8'd0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_drain_pause();
        test_random_source();
        test_no_idle();

        @(negedge i_clk);
        src.valid = 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d source bytes, checked %0d tokens, %0d mismatches.",
                 bytes_sent, tokens_seen, mismatches + token_q.size());
        $display("Covered keywords, operators, numbers, escapes, comments, full-rate bursts.");
        if (mismatches == 0 && token_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
src/c_lex_pkg.sv
src/c_lex_if.sv
src/c_lex_front.sv
src/c_lex_back.sv
src/c_subset_lexer_core.sv
test/c_subset_lexer_core_test.sv
